>>> sv/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg: shared definitions for the periodic task tick scheduler
// Field widths, opcodes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned MASK_OUT_W = 8;
  localparam int unsigned TPS_W      = 11;
  localparam int unsigned SPM_W      = 7;
  localparam int unsigned SUBS_W     = 10;
  localparam int unsigned SUBM_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [TPS_W-1:0] TPS_MIN   = 11'd1;
  localparam logic [TPS_W-1:0] TPS_MAX   = 11'd1024;
  localparam logic [TPS_W-1:0] TPS_RESET = 11'd1000;
  localparam logic [SPM_W-1:0] SPM_MIN   = 7'd1;
  localparam logic [SPM_W-1:0] SPM_MAX   = 7'd64;
  localparam logic [SPM_W-1:0] SPM_RESET = 7'd60;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDS_PER_MINUTE = 2'd1;

  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take the input word and load the result register
    logic scan_en;  // update the slot under the scan pointer and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last slot
  } status_t;

endpackage

>>> sv/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl: scheduler controller
// Sequences input acceptance, the per-slot tick scan and the result handshake.
// ----------------------------------------------------------------------------
module ptts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptts_pkg::OPCODE_W-1:0] opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ptts_pkg::cmd_t                cmd_o,
  input  ptts_pkg::status_t             status_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load    = accept;
  assign cmd_o.scan_en = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (opcode_i == ptts_pkg::OP_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/ptts_datapath.sv
// ----------------------------------------------------------------------------
// ptts_datapath: scheduler datapath
// Slot table, time counters, configuration registers and result register.
// ----------------------------------------------------------------------------
module ptts_datapath #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptts_pkg::cmd_t                   cmd_i,
  output ptts_pkg::status_t                status_o,
  input  logic [ptts_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [ptts_pkg::PERIOD_W-1:0]    period_i,
  input  logic                             cfg_we_i,
  input  logic [ptts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [ptts_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic                             create_failed_o,
  output logic [ptts_pkg::MASK_OUT_W-1:0]  run_mask_o,
  output logic [ptts_pkg::CNT_W-1:0]       millisecond_count_o,
  output logic [ptts_pkg::CNT_W-1:0]       second_count_o,
  output logic [ptts_pkg::CNT_W-1:0]       minute_count_o
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  // Slot table
  logic [NUM_SLOTS-1:0]                 en_q, pend_q;
  logic [ptts_pkg::PERIOD_W-1:0]        cd_q  [NUM_SLOTS];
  logic [ptts_pkg::PERIOD_W-1:0]        per_q [NUM_SLOTS];
  logic [SW-1:0]                        idx_q;

  // Time base and configuration
  logic [ptts_pkg::CNT_W-1:0]  tick_q, sec_q, min_q, tick_d, sec_d, min_d;
  logic [ptts_pkg::SUBS_W-1:0] subs_q, subs_d;
  logic [ptts_pkg::SUBM_W-1:0] subm_q, subm_d;
  logic [ptts_pkg::TPS_W-1:0]  tps_q, tps_eff;
  logic [ptts_pkg::SPM_W-1:0]  spm_q, spm_eff;

  // Result register
  logic [SW-1:0]                       res_slot_q;
  logic                                res_fail_q;
  logic [NUM_SLOTS-1:0]                res_mask_q;
  logic [ptts_pkg::CNT_W-1:0]          res_tick_q, res_sec_q, res_min_q;

  logic                                is_tick, is_create, is_dispatch;
  logic [SW-1:0]                       free_idx;
  logic                                free_found;
  logic [ptts_pkg::PERIOD_W-1:0]       cd_cur, cd_dec;
  logic                                fire;

  assign is_tick     = (opcode_i == ptts_pkg::OP_TICK);
  assign is_create   = (opcode_i == ptts_pkg::OP_CREATE);
  assign is_dispatch = (opcode_i == ptts_pkg::OP_DISPATCH);

  assign status_o.scan_last = (idx_q == LAST_SLOT);

  // Lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!en_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Saturate the limits, then advance the time base
  always_comb begin
    if (tps_q < ptts_pkg::TPS_MIN) tps_eff = ptts_pkg::TPS_MIN;
    else if (tps_q > ptts_pkg::TPS_MAX) tps_eff = ptts_pkg::TPS_MAX;
    else tps_eff = tps_q;
    if (spm_q < ptts_pkg::SPM_MIN) spm_eff = ptts_pkg::SPM_MIN;
    else if (spm_q > ptts_pkg::SPM_MAX) spm_eff = ptts_pkg::SPM_MAX;
    else spm_eff = spm_q;

    tick_d = tick_q + 1'b1;
    sec_d  = sec_q;
    min_d  = min_q;
    subs_d = subs_q + 1'b1;
    subm_d = subm_q;
    if (({1'b0, subs_q} + 1'b1) >= tps_eff) begin
      subs_d = '0;
      sec_d  = sec_q + 1'b1;
      if (({1'b0, subm_q} + 1'b1) >= spm_eff) begin
        subm_d = '0;
        min_d  = min_q + 1'b1;
      end else begin
        subm_d = subm_q + 1'b1;
      end
    end
  end

  // Slot under the scan pointer
  assign cd_cur = cd_q[idx_q];
  assign cd_dec = (cd_cur != '0) ? cd_cur - 1'b1 : cd_cur;
  assign fire   = (cd_dec == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      pend_q <= '0;
      idx_q  <= '0;
      tick_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      subs_q <= '0;
      subm_q <= '0;
      tps_q  <= ptts_pkg::TPS_RESET;
      spm_q  <= ptts_pkg::SPM_RESET;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == ptts_pkg::REG_TICKS_PER_SECOND) begin
          tps_q <= cfg_data_i[ptts_pkg::TPS_W-1:0];
        end else if (cfg_index_i == ptts_pkg::REG_SECONDS_PER_MINUTE) begin
          spm_q <= cfg_data_i[ptts_pkg::SPM_W-1:0];
        end
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        if (is_tick) begin
          tick_q <= tick_d;
          sec_q  <= sec_d;
          min_q  <= min_d;
          subs_q <= subs_d;
          subm_q <= subm_d;
        end else if (is_create && free_found) begin
          en_q[free_idx]   <= 1'b1;
          pend_q[free_idx] <= 1'b0;
        end else if (is_dispatch) begin
          pend_q <= '0;
        end
      end else if (cmd_i.scan_en) begin
        idx_q <= status_o.scan_last ? '0 : idx_q + 1'b1;
        if (en_q[idx_q] && fire) begin
          pend_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  // Payload: countdown, period and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (is_create && free_found) begin
        cd_q[free_idx]  <= '0;
        per_q[free_idx] <= period_i;
      end
      res_slot_q <= (is_create && free_found) ? free_idx : '0;
      res_fail_q <= is_create && !free_found;
      res_mask_q <= is_dispatch ? (en_q & pend_q) : '0;
      res_tick_q <= is_tick ? tick_d : tick_q;
      res_sec_q  <= is_tick ? sec_d  : sec_q;
      res_min_q  <= is_tick ? min_d  : min_q;
    end else if (cmd_i.scan_en && en_q[idx_q]) begin
      cd_q[idx_q] <= fire ? per_q[idx_q] : cd_dec;
    end
  end

  // Fit slot index and mask to the fixed output widths
  for (genvar b = 0; b < ptts_pkg::SLOT_OUT_W; b++) begin : g_slot
    if (b < SW) begin : g_bit
      assign slot_index_o[b] = res_slot_q[b];
    end else begin : g_zero
      assign slot_index_o[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < ptts_pkg::MASK_OUT_W; b++) begin : g_mask
    if (b < NUM_SLOTS) begin : g_bit
      assign run_mask_o[b] = res_mask_q[b];
    end else begin : g_zero
      assign run_mask_o[b] = 1'b0;
    end
  end

  assign create_failed_o     = res_fail_q;
  assign millisecond_count_o = res_tick_q;
  assign second_count_o      = res_sec_q;
  assign minute_count_o      = res_min_q;

endmodule

>>> sv/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: cooperative periodic task scheduler
// Slot table of periodic tasks driven by tick, create and dispatch words.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  opcode_i, period_i
//   out       output     out_valid_o/out_ready_i slot_index_o, create_failed_o,
//                                               run_mask_o, *_count_o
//   cfg       input      cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// Sequencing: create and dispatch words are done when accepted; a tick word
// advances the time base when accepted and then visits every slot in turn
// as the scan pointer walks the slot table through a single update unit.
// Reset: asynchronous, active low; clears enables, pending flags, counters
// and loads the default limits. No clearing pass is needed.
// Stalls: the result sits in an output register until taken; a new word is
// accepted while idle, with that register empty or drained in the same cycle.
//
module periodic_task_tick_scheduler #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ptts_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [ptts_pkg::PERIOD_W-1:0]    period_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptts_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic                             create_failed_o,
  output logic [ptts_pkg::MASK_OUT_W-1:0]  run_mask_o,
  output logic [ptts_pkg::CNT_W-1:0]       millisecond_count_o,
  output logic [ptts_pkg::CNT_W-1:0]       second_count_o,
  output logic [ptts_pkg::CNT_W-1:0]       minute_count_o,
  input  logic                             cfg_we_i,
  input  logic [ptts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ptts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ptts_pkg::cmd_t    cmd;
  ptts_pkg::status_t status;

  // Controller: owns the state machine and the result valid flag
  ptts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath: slot table, time base, limits and result payload
  ptts_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .opcode_i            (opcode_i),
    .period_i            (period_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .slot_index_o        (slot_index_o),
    .create_failed_o     (create_failed_o),
    .run_mask_o          (run_mask_o),
    .millisecond_count_o (millisecond_count_o),
    .second_count_o      (second_count_o),
    .minute_count_o      (minute_count_o)
  );

  // Never take a word while an untaken result would be overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input accepted over a pending result");

  // A tick word keeps the input closed while the slot scan runs
  a_tick_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == ptts_pkg::OP_TICK)) |=> !in_ready_o)
    else $error("input reopened during slot scan");

  // Scan activity and word acceptance are exclusive
  a_scan_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.scan_en))
    else $error("load and scan in the same cycle");

  // A failed create reports slot zero
  a_fail_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && create_failed_o) |-> (slot_index_o == '0) && (run_mask_o == '0))
    else $error("failed create carries a slot or mask");

endmodule

>>> dv/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler: self-checking bench for the tick scheduler
// Drives tick, create, dispatch and spare words through the input channel,
// keeps its own copy of the slot table and time base, and compares every
// status word on the output channel with the predicted one, field by field.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;

  localparam int unsigned NUM_SLOTS = 8;
  // Opcode 3 has no meaning in the block: it must leave all state alone.
  localparam logic [ptts_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE  = 225;
  localparam int NUM_PHASES       = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT      = 4000;
  localparam int MAX_SHOWN        = 10;
  // A tick word walks the whole table: allow for that before touching limits.
  localparam int SETTLE_CYCLES    = NUM_SLOTS + 4;

  // One status word as it leaves the block.
  typedef struct packed {
    logic [ptts_pkg::SLOT_OUT_W-1:0] slot;
    logic                            failed;
    logic [ptts_pkg::MASK_OUT_W-1:0] mask;
    logic [ptts_pkg::CNT_W-1:0]      ms;
    logic [ptts_pkg::CNT_W-1:0]      sec;
    logic [ptts_pkg::CNT_W-1:0]      mins;
  } sched_word_t;

  // One row of the directed table; typed rows carry the status word inline.
  typedef struct packed {
    logic [ptts_pkg::OPCODE_W-1:0] op;
    logic [ptts_pkg::PERIOD_W-1:0] per;
    logic                          typed;
    sched_word_t                   word;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [ptts_pkg::OPCODE_W-1:0]    opcode_i;
  logic [ptts_pkg::PERIOD_W-1:0]    period_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [ptts_pkg::SLOT_OUT_W-1:0]  slot_index_o;
  logic                             create_failed_o;
  logic [ptts_pkg::MASK_OUT_W-1:0]  run_mask_o;
  logic [ptts_pkg::CNT_W-1:0]       millisecond_count_o;
  logic [ptts_pkg::CNT_W-1:0]       second_count_o;
  logic [ptts_pkg::CNT_W-1:0]       minute_count_o;
  logic                             cfg_we_i;
  logic [ptts_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [ptts_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  periodic_task_tick_scheduler #(
    .NUM_SLOTS(NUM_SLOTS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .period_i           (period_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .slot_index_o       (slot_index_o),
    .create_failed_o    (create_failed_o),
    .run_mask_o         (run_mask_o),
    .millisecond_count_o(millisecond_count_o),
    .second_count_o     (second_count_o),
    .minute_count_o     (minute_count_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the scheduler: slot table, time base and limit registers
  // --------------------------------------------------------------------------
  logic                          slot_on   [NUM_SLOTS];
  logic                          slot_due  [NUM_SLOTS];
  logic [ptts_pkg::CNT_W-1:0]    slot_left [NUM_SLOTS];
  logic [ptts_pkg::CNT_W-1:0]    slot_per  [NUM_SLOTS];
  logic [ptts_pkg::CNT_W-1:0]    ms_total   = '0;
  logic [ptts_pkg::CNT_W-1:0]    sec_total  = '0;
  logic [ptts_pkg::CNT_W-1:0]    min_total  = '0;
  int                            sub_ticks  = 0;
  int                            sub_secs   = 0;
  logic [ptts_pkg::TPS_W-1:0]    tps_reg    = ptts_pkg::TPS_RESET;
  logic [ptts_pkg::SPM_W-1:0]    spm_reg    = ptts_pkg::SPM_RESET;

  sched_word_t status_backlog [$];
  int          mismatches   = 0;
  bit          hold_off_req = 1'b0;
  bit          calm         = 1'b0;

  // Limit settings per random phase: minimum, maximum, out of range both
  // ways, then lowered limits so that the sub-counters overshoot them.
  int phase_tps [NUM_PHASES] = '{1, 1024, 2047, 0, 150, 2, 1, 3};
  int phase_spm [NUM_PHASES] = '{1, 64, 127, 0, 64, 5, 64, 2};

  // Apply one word to the shadow state and return the status it produces.
  function automatic sched_word_t step_schedule(input logic [ptts_pkg::OPCODE_W-1:0] op,
                                                input logic [ptts_pkg::PERIOD_W-1:0] per);
    sched_word_t w;
    int          tps;
    int          spm;
    bit          found;
    w     = '0;
    found = 1'b0;
    case (op)
      ptts_pkg::OP_TICK: begin
        // Saturate the limits at the point of use.
        tps = (tps_reg < ptts_pkg::TPS_MIN) ? int'(ptts_pkg::TPS_MIN) :
              (tps_reg > ptts_pkg::TPS_MAX) ? int'(ptts_pkg::TPS_MAX) : int'(tps_reg);
        spm = (spm_reg < ptts_pkg::SPM_MIN) ? int'(ptts_pkg::SPM_MIN) :
              (spm_reg > ptts_pkg::SPM_MAX) ? int'(ptts_pkg::SPM_MAX) : int'(spm_reg);
        ms_total = ms_total + 1'b1;
        // A sub-counter at or past a lowered limit rolls over here.
        if (sub_ticks + 1 >= tps) begin
          sub_ticks = 0;
          sec_total = sec_total + 1'b1;
          if (sub_secs + 1 >= spm) begin
            sub_secs  = 0;
            min_total = min_total + 1'b1;
          end else begin
            sub_secs = (sub_secs + 1) & 63;
          end
        end else begin
          sub_ticks = (sub_ticks + 1) & 1023;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i]) begin
            if (slot_left[i] != '0) slot_left[i] = slot_left[i] - 1'b1;
            if (slot_left[i] == '0) begin
              slot_due[i]  = 1'b1;
              slot_left[i] = slot_per[i];
            end
          end
        end
      end
      ptts_pkg::OP_CREATE: begin
        w.failed = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!found && !slot_on[i]) begin
            found        = 1'b1;
            slot_on[i]   = 1'b1;
            slot_due[i]  = 1'b0;
            slot_left[i] = '0;
            slot_per[i]  = per;
            w.slot       = i[ptts_pkg::SLOT_OUT_W-1:0];
            w.failed     = 1'b0;
          end
        end
      end
      ptts_pkg::OP_DISPATCH: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i] && slot_due[i]) w.mask[i] = 1'b1;
          slot_due[i] = 1'b0;
        end
      end
      default: ;
    endcase
    w.ms   = ms_total;
    w.sec  = sec_total;
    w.mins = min_total;
    return w;
  endfunction

  function automatic stim_row_t row(input logic [ptts_pkg::OPCODE_W-1:0] op,
                                    input logic [ptts_pkg::PERIOD_W-1:0] per,
                                    input logic typed,
                                    input logic [ptts_pkg::SLOT_OUT_W-1:0] slot,
                                    input logic failed,
                                    input logic [ptts_pkg::MASK_OUT_W-1:0] mask,
                                    input logic [ptts_pkg::CNT_W-1:0] ms);
    stim_row_t r;
    r.op          = op;
    r.per         = per;
    r.typed       = typed;
    r.word        = '0;
    r.word.slot   = slot;
    r.word.failed = failed;
    r.word.mask   = mask;
    r.word.ms     = ms;
    return r;
  endfunction

  // Offer one word, hold it until taken, then queue its status.
  task automatic send_word(input logic [ptts_pkg::OPCODE_W-1:0] op,
                           input logic [ptts_pkg::PERIOD_W-1:0] per,
                           input logic typed, input sched_word_t fixed);
    sched_word_t w;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    period_i   <= per;
    do @(posedge clk_i); while (!in_ready_o);
    w = step_schedule(op, per);
    status_backlog.push_back(typed ? fixed : w);
  endtask

  // Drop valid, wait for every status word, then let a tick scan finish.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_backlog.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the tick limit, then the minute limit; the block is idle here.
  // Junk goes into the unused upper bits of the minute limit write.
  task automatic load_limits(input int tps, input int spm);
    logic [ptts_pkg::CFG_DATA_W-1:0] spm_word;
    spm_word    = {4'($urandom()), 7'(spm)};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ptts_pkg::REG_TICKS_PER_SECOND;
    cfg_data_i  <= 11'(tps);
    @(posedge clk_i);
    cfg_index_i <= ptts_pkg::REG_SECONDS_PER_MINUTE;
    cfg_data_i  <= spm_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tps_reg = 11'(tps);
    spm_reg = spm_word[ptts_pkg::SPM_W-1:0];
  endtask

  task automatic note_field(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, directed table, then random phases under changing limits
  // --------------------------------------------------------------------------
  initial begin : feed
    stim_row_t rows [$];
    logic [ptts_pkg::OPCODE_W-1:0] op;
    int r;
    int gap;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = ptts_pkg::OP_TICK;
    period_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = ptts_pkg::REG_TICKS_PER_SECOND;
    cfg_data_i  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i]   = 1'b0;
      slot_due[i]  = 1'b0;
      slot_left[i] = '0;
      slot_per[i]  = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh block: nothing due, spare opcode inert, new slots fire on the
    // next tick, the table fills from slot 0 and then refuses creates.
    rows.push_back(row(ptts_pkg::OP_DISPATCH, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(OP_SPARE,              16'hFFFF, 1'b1, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_TICK,     16'h0000, 1'b1, 3'd0, 1'b0, 8'h00, 16'd1));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0000, 1'b1, 3'd0, 1'b0, 8'h00, 16'd1));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'hFFFF, 1'b1, 3'd1, 1'b0, 8'h00, 16'd1));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0001, 1'b1, 3'd2, 1'b0, 8'h00, 16'd1));
    rows.push_back(row(ptts_pkg::OP_TICK,     16'h5A5A, 1'b1, 3'd0, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_DISPATCH, 16'hA5A5, 1'b1, 3'd0, 1'b0, 8'h07, 16'd2));
    rows.push_back(row(ptts_pkg::OP_DISPATCH, 16'h0000, 1'b1, 3'd0, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0002, 1'b1, 3'd3, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0003, 1'b1, 3'd4, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0005, 1'b1, 3'd5, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0007, 1'b1, 3'd6, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h0010, 1'b1, 3'd7, 1'b0, 8'h00, 16'd2));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'h1234, 1'b1, 3'd0, 1'b1, 8'h00, 16'd2));
    // From here on the shadow model supplies the status.
    rows.push_back(row(ptts_pkg::OP_TICK,     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_TICK,     16'hFFFF, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_TICK,     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_DISPATCH, 16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_TICK,     16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(OP_SPARE,              16'h0000, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_DISPATCH, 16'hFFFF, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));
    rows.push_back(row(ptts_pkg::OP_CREATE,   16'hFFFF, 1'b0, 3'd0, 1'b0, 8'h00, 16'd0));

    for (int k = 0; k < rows.size(); k++)
      send_word(rows[k].op, rows[k].per, rows[k].typed, rows[k].word);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_quiet();
      load_limits(phase_tps[p], phase_spm[p]);
      // Run the last phase flat out on both sides.
      if (p == NUM_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Ask the receiver for a long hold-off while words keep coming.
        if (p == 2 && n == 40) hold_off_req = 1'b1;
        if (p == 4 && n == 100) begin
          // Pause until every outstanding status word has come back.
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (status_backlog.size() != 0);
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 18);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        // Mostly ticks and dispatches; creates can only fail by now.
        r  = $urandom_range(0, 99);
        op = (r < 58) ? ptts_pkg::OP_TICK :
             (r < 88) ? ptts_pkg::OP_DISPATCH :
             (r < 96) ? ptts_pkg::OP_CREATE : OP_SPARE;
        send_word(op, 16'($urandom()), 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && status_backlog.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none when calm
  // --------------------------------------------------------------------------
  initial begin : drain
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted status word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : status_check
    sched_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_backlog.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: status word with none outstanding: ms %0d", $realtime,
                   millisecond_count_o);
      end else begin
        want = status_backlog.pop_front();
        note_field("slot_index",        32'(want.slot),   32'(slot_index_o));
        note_field("create_failed",     32'(want.failed), 32'(create_failed_o));
        note_field("run_mask",          32'(want.mask),   32'(run_mask_o));
        note_field("millisecond_count", 32'(want.ms),     32'(millisecond_count_o));
        note_field("second_count",      32'(want.sec),    32'(second_count_o));
        note_field("minute_count",      32'(want.mins),   32'(minute_count_o));
      end
    end
  end

  // Abort when neither channel moves a word for too long.
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

>>> files.f
sv/ptts_pkg.sv
sv/ptts_ctrl.sv
sv/ptts_datapath.sv
sv/periodic_task_tick_scheduler.sv
dv/tb_periodic_task_tick_scheduler.sv
